// ===== design/assert_macros.svh =====
// Assertion macros used by the request queue of the serial line calculator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SLC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");
`define SLC_ASSERT_IMPL(label, cond, conseq) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (conseq)) else $error("assertion failed");
`else
`define SLC_ASSERT(label, prop)
`define SLC_ASSERT_IMPL(label, cond, conseq)
`endif
`endif

// ===== design/slc_pkg.sv =====
// Package with the types, character codes and fixed texts of the serial line calculator.
`timescale 1ns / 1ps
package slc_pkg;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [4:0] ERR_LAST = 5'd30;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] op;
    } t_cmd;

    typedef enum logic [1:0] {
        PH_BLANK = 2'd0,
        PH_SIGN  = 2'd1,
        PH_DIGIT = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        LS_FIRST  = 2'd0,
        LS_SECOND = 2'd1,
        LS_OPER   = 2'd2
    } t_line_stage;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_SEG, S_CONV, S_NUM, S_ERR
    } t_back_state;

    typedef enum logic [3:0] {
        SEG_X, SEG_SP1, SEG_OP, SEG_SP2, SEG_Y, SEG_SP3, SEG_EQ, SEG_SP4,
        SEG_MINUS, SEG_RES, SEG_SP5, SEG_LF
    } t_seg;

    function automatic logic [7:0] err_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:  c = "N";
            5'd1:  c = "i";
            5'd2:  c = "e";
            5'd3:  c = " ";
            5'd4:  c = "d";
            5'd5:  c = "z";
            5'd6:  c = "i";
            5'd7:  c = "e";
            5'd8:  c = "l";
            5'd9:  c = " ";
            5'd10: c = "c";
            5'd11: c = "h";
            5'd12: c = "o";
            5'd13: c = "l";
            5'd14: c = "e";
            5'd15: c = "r";
            5'd16: c = "o";
            5'd17: c = " ";
            5'd18: c = "p";
            5'd19: c = "r";
            5'd20: c = "z";
            5'd21: c = "e";
            5'd22: c = "z";
            5'd23: c = " ";
            5'd24: c = "z";
            5'd25: c = "e";
            5'd26: c = "r";
            5'd27: c = "o";
            5'd28: c = "!";
            5'd29: c = " ";
            5'd30: c = CH_LF;
            default: c = CH_LF;
        endcase
        return c;
    endfunction
endpackage

// ===== design/slc_front.sv =====
// Line parser that collects operands and issues calculation requests.
`timescale 1ns / 1ps
module slc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rx_valid,
    output logic             o_rx_ready,
    input  logic [7:0]       i_rx_byte,
    output logic             o_push,
    output slc_pkg::t_cmd    o_cmd,
    input  logic             i_q_ready
);
    slc_pkg::t_line_stage r_stage, n_stage;
    slc_pkg::t_phase      r_phase, n_phase;
    logic [7:0] r_first, n_first;
    logic [7:0] r_second, n_second;
    logic [7:0] r_acc, n_acc;
    logic       r_minus, n_minus;
    logic [7:0] r_first_char, n_first_char;
    logic [3:0] r_pos, n_pos;

    logic       accept, term, digit, blank, op_ok;
    logic [7:0] c, val, op, dig;

    assign c          = i_rx_byte;
    assign o_rx_ready = i_q_ready;
    assign accept     = i_rx_valid && o_rx_ready;
    assign term       = (c == slc_pkg::CH_LF) || (c == slc_pkg::CH_CR);
    assign digit      = (c >= 8'h30) && (c <= 8'h39);
    assign blank      = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
    assign dig        = c - slc_pkg::CH_ZERO;
    assign val        = r_minus ? (8'h00 - r_acc) : r_acc;
    assign op         = (r_pos == 4'd0) ? c : r_first_char;
    assign op_ok      = (op == slc_pkg::CH_PLUS) || (op == slc_pkg::CH_MINUS) ||
                        (op == slc_pkg::CH_STAR) || (op == slc_pkg::CH_SLASH);
    assign o_push     = accept && term && (r_stage == slc_pkg::LS_OPER) && op_ok;
    assign o_cmd      = '{x: r_first, y: r_second, op: op};

    always_comb begin
        n_stage      = r_stage;
        n_phase      = r_phase;
        n_first      = r_first;
        n_second     = r_second;
        n_acc        = r_acc;
        n_minus      = r_minus;
        n_first_char = r_first_char;
        n_pos        = r_pos;
        if (accept && term) begin
            case (r_stage)
                slc_pkg::LS_FIRST: begin
                    n_first = val;
                    n_stage = slc_pkg::LS_SECOND;
                end
                slc_pkg::LS_SECOND: begin
                    n_second = val;
                    n_stage  = slc_pkg::LS_OPER;
                end
                default: n_stage = slc_pkg::LS_FIRST;
            endcase
            n_acc        = 8'h00;
            n_phase      = slc_pkg::PH_BLANK;
            n_minus      = 1'b0;
            n_first_char = 8'h00;
            n_pos        = 4'd0;
        end else if (accept) begin
            if (r_pos == 4'd0) begin
                n_first_char = c;
            end
            if (r_pos != 4'd15) begin
                n_pos = r_pos + 4'd1;
            end
            case (r_phase)
                slc_pkg::PH_BLANK: begin
                    if (blank) begin
                        n_phase = slc_pkg::PH_BLANK;
                    end else if (c == slc_pkg::CH_PLUS || c == slc_pkg::CH_MINUS) begin
                        n_minus = (c == slc_pkg::CH_MINUS);
                        n_phase = slc_pkg::PH_SIGN;
                    end else if (digit) begin
                        n_acc   = dig;
                        n_phase = slc_pkg::PH_DIGIT;
                    end else begin
                        n_phase = slc_pkg::PH_DONE;
                    end
                end
                slc_pkg::PH_SIGN, slc_pkg::PH_DIGIT: begin
                    if (digit) begin
                        n_acc   = (r_acc << 3) + (r_acc << 1) + dig;
                        n_phase = slc_pkg::PH_DIGIT;
                    end else begin
                        n_phase = slc_pkg::PH_DONE;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage      <= slc_pkg::LS_FIRST;
            r_phase      <= slc_pkg::PH_BLANK;
            r_first      <= 8'h00;
            r_second     <= 8'h00;
            r_acc        <= 8'h00;
            r_minus      <= 1'b0;
            r_first_char <= 8'h00;
            r_pos        <= 4'd0;
        end else begin
            r_stage      <= n_stage;
            r_phase      <= n_phase;
            r_first      <= n_first;
            r_second     <= n_second;
            r_acc        <= n_acc;
            r_minus      <= n_minus;
            r_first_char <= n_first_char;
            r_pos        <= n_pos;
        end
    end
endmodule

// ===== design/slc_queue.sv =====
// Small request queue between the line parser and the response generator.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module slc_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  slc_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output slc_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    slc_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push && o_ready) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && o_ready) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop && o_valid) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            case ({i_push && o_ready, i_pop && o_valid})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `SLC_ASSERT(a_cnt_bound, r_cnt <= CW'(DEPTH))
    `SLC_ASSERT_IMPL(a_no_push_full, r_cnt == CW'(DEPTH), !o_ready)
    `SLC_ASSERT_IMPL(a_pop_empty, i_pop && !o_valid, ##1 $stable(r_rd))
endmodule

// ===== design/slc_back.sv =====
// Response generator: computes the result and sends the response text byte by byte.
`timescale 1ns / 1ps
module slc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  slc_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_tx_valid,
    input  logic          i_tx_ready,
    output logic [7:0]    o_tx_byte,
    output logic          o_tx_last
);
    slc_pkg::t_back_state r_state, n_state;
    slc_pkg::t_seg        r_seg, n_seg;
    logic [7:0]  r_x, n_x, r_y, n_y, r_op, n_op;
    logic        r_neg, n_neg;
    logic [15:0] r_res, n_res;
    logic [19:0] r_bcd, n_bcd;
    logic [15:0] r_bin, n_bin;
    logic [3:0]  r_cnt, n_cnt;
    logic [2:0]  r_dig, n_dig;
    logic        r_started, n_started;
    logic [8:0]  r_rem, n_rem;
    logic [7:0]  r_quo, n_quo;
    logic [4:0]  r_eidx, n_eidx;
    logic        r_ov, n_ov;
    logic [7:0]  r_ob, n_ob;
    logic        r_ol, n_ol;

    logic        can_emit, is_num_seg, skip_minus, div_zero;
    logic [7:0]  seg_char;
    logic [15:0] seg_val;
    logic [3:0]  cur_digit;
    logic [8:0]  rem_sh;
    logic [19:0] bcd_adj;

    assign can_emit   = !r_ov || i_tx_ready;
    assign o_tx_valid = r_ov;
    assign o_tx_byte  = r_ob;
    assign o_tx_last  = r_ol;
    assign o_pop      = (r_state == slc_pkg::S_IDLE) && i_cmd_valid;
    assign div_zero   = (i_cmd.op == slc_pkg::CH_SLASH) && (i_cmd.y == 8'h00);
    assign is_num_seg = (r_seg == slc_pkg::SEG_X) || (r_seg == slc_pkg::SEG_Y) ||
                        (r_seg == slc_pkg::SEG_RES);
    assign skip_minus = (r_seg == slc_pkg::SEG_MINUS) && !r_neg;
    assign cur_digit  = r_bcd[{r_dig, 2'b00} +: 4];
    assign rem_sh     = {r_rem[7:0], r_quo[7]};

    always_comb begin
        case (r_seg)
            slc_pkg::SEG_OP:    seg_char = r_op;
            slc_pkg::SEG_EQ:    seg_char = slc_pkg::CH_EQUAL;
            slc_pkg::SEG_MINUS: seg_char = slc_pkg::CH_MINUS;
            slc_pkg::SEG_LF:    seg_char = slc_pkg::CH_LF;
            default:            seg_char = slc_pkg::CH_SPACE;
        endcase
        case (r_seg)
            slc_pkg::SEG_X: seg_val = {8'h00, r_x};
            slc_pkg::SEG_Y: seg_val = {8'h00, r_y};
            default:        seg_val = r_res;
        endcase
        for (int k = 0; k < 5; k++) begin
            bcd_adj[k*4 +: 4] = (r_bcd[k*4 +: 4] >= 4'd5) ?
                                r_bcd[k*4 +: 4] + 4'd3 : r_bcd[k*4 +: 4];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            slc_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    if (div_zero) begin
                        n_state = slc_pkg::S_ERR;
                    end else if (i_cmd.op == slc_pkg::CH_SLASH) begin
                        n_state = slc_pkg::S_DIV;
                    end else begin
                        n_state = slc_pkg::S_SEG;
                    end
                end
            end
            slc_pkg::S_DIV: begin
                if (r_cnt == 4'd7) begin
                    n_state = slc_pkg::S_SEG;
                end
            end
            slc_pkg::S_SEG: begin
                if (is_num_seg) begin
                    n_state = slc_pkg::S_CONV;
                end else if (can_emit && !skip_minus && r_seg == slc_pkg::SEG_LF) begin
                    n_state = slc_pkg::S_IDLE;
                end
            end
            slc_pkg::S_CONV: begin
                if (r_cnt == 4'd15) begin
                    n_state = slc_pkg::S_NUM;
                end
            end
            slc_pkg::S_NUM: begin
                if ((r_started || cur_digit != 4'd0 || r_dig == 3'd0) && can_emit &&
                    r_dig == 3'd0) begin
                    n_state = slc_pkg::S_SEG;
                end
            end
            slc_pkg::S_ERR: begin
                if (can_emit && r_eidx == slc_pkg::ERR_LAST) begin
                    n_state = slc_pkg::S_IDLE;
                end
            end
            default: n_state = slc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_seg     = r_seg;
        n_x       = r_x;
        n_y       = r_y;
        n_op      = r_op;
        n_neg     = r_neg;
        n_res     = r_res;
        n_bcd     = r_bcd;
        n_bin     = r_bin;
        n_cnt     = r_cnt;
        n_dig     = r_dig;
        n_started = r_started;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_eidx    = r_eidx;
        n_ov      = r_ov && !i_tx_ready;
        n_ob      = r_ob;
        n_ol      = r_ol;
        case (r_state)
            slc_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    n_x    = i_cmd.x;
                    n_y    = i_cmd.y;
                    n_op   = i_cmd.op;
                    n_seg  = slc_pkg::SEG_X;
                    n_eidx = 5'd0;
                    n_cnt  = 4'd0;
                    n_rem  = 9'd0;
                    n_quo  = i_cmd.x;
                    n_neg  = (i_cmd.op == slc_pkg::CH_MINUS) && (i_cmd.x < i_cmd.y);
                    case (i_cmd.op)
                        slc_pkg::CH_PLUS:  n_res = {8'h00, i_cmd.x} + {8'h00, i_cmd.y};
                        slc_pkg::CH_MINUS: n_res = (i_cmd.x < i_cmd.y) ?
                                                   {8'h00, i_cmd.y - i_cmd.x} :
                                                   {8'h00, i_cmd.x - i_cmd.y};
                        slc_pkg::CH_STAR:  n_res = {8'h00, i_cmd.x} * {8'h00, i_cmd.y};
                        default:           n_res = 16'h0000;
                    endcase
                end
            end
            slc_pkg::S_DIV: begin
                if (rem_sh >= {1'b0, r_y}) begin
                    n_rem = rem_sh - {1'b0, r_y};
                    n_quo = {r_quo[6:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_quo = {r_quo[6:0], 1'b0};
                end
                n_cnt = r_cnt + 4'd1;
                n_res = {8'h00, n_quo};
            end
            slc_pkg::S_SEG: begin
                if (is_num_seg) begin
                    n_bin = seg_val;
                    n_bcd = 20'h00000;
                    n_cnt = 4'd0;
                end else if (skip_minus) begin
                    n_seg = slc_pkg::t_seg'(r_seg + 4'd1);
                end else if (can_emit) begin
                    n_ov = 1'b1;
                    n_ob = seg_char;
                    n_ol = (r_seg == slc_pkg::SEG_LF);
                    if (r_seg != slc_pkg::SEG_LF) begin
                        n_seg = slc_pkg::t_seg'(r_seg + 4'd1);
                    end
                end
            end
            slc_pkg::S_CONV: begin
                n_bcd     = {bcd_adj[18:0], r_bin[15]};
                n_bin     = {r_bin[14:0], 1'b0};
                n_cnt     = r_cnt + 4'd1;
                n_dig     = 3'd4;
                n_started = 1'b0;
            end
            slc_pkg::S_NUM: begin
                if (!r_started && cur_digit == 4'd0 && r_dig != 3'd0) begin
                    n_dig = r_dig - 3'd1;
                end else if (can_emit) begin
                    n_ov      = 1'b1;
                    n_ob      = slc_pkg::CH_ZERO + {4'h0, cur_digit};
                    n_ol      = 1'b0;
                    n_started = 1'b1;
                    if (r_dig == 3'd0) begin
                        n_seg = slc_pkg::t_seg'(r_seg + 4'd1);
                    end else begin
                        n_dig = r_dig - 3'd1;
                    end
                end
            end
            slc_pkg::S_ERR: begin
                if (can_emit) begin
                    n_ov   = 1'b1;
                    n_ob   = slc_pkg::err_char(r_eidx);
                    n_ol   = (r_eidx == slc_pkg::ERR_LAST);
                    n_eidx = r_eidx + 5'd1;
                end
            end
            default: n_ov = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slc_pkg::S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seg     <= n_seg;
        r_x       <= n_x;
        r_y       <= n_y;
        r_op      <= n_op;
        r_neg     <= n_neg;
        r_res     <= n_res;
        r_bcd     <= n_bcd;
        r_bin     <= n_bin;
        r_cnt     <= n_cnt;
        r_dig     <= n_dig;
        r_started <= n_started;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_eidx    <= n_eidx;
        r_ob      <= n_ob;
        r_ol      <= n_ol;
    end
endmodule

// ===== design/serial_line_calculator.sv =====
// Top level of the serial line calculator: parser, request queue and response generator.
//
//   channel   direction  handshake                 payload
//   rx        in         i_rx_valid / o_rx_ready   i_rx_byte
//   tx        out        o_tx_valid / i_tx_ready   o_tx_byte, o_tx_last
//
// A received byte is taken whenever the request queue has room.
// A request is taken while the generator is idle; a quotient is found by restoring division.
// Each printed number is converted from binary to decimal by shift-and-add-3, leading zeros
// are skipped and its digits are sent in order; every other character is sent directly.
// The error text is sent character by character. Reset is synchronous and active low.
// A stalled output holds its byte; the parser keeps taking bytes until the queue fills.
`timescale 1ns / 1ps
module serial_line_calculator #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_tx_valid,
    input  logic       i_tx_ready,
    output logic [7:0] o_tx_byte,
    output logic       o_tx_last
);
    logic          push, q_ready, q_valid, pop;
    slc_pkg::t_cmd push_cmd, pop_cmd;

    slc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_rx_byte  (i_rx_byte),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .i_q_ready  (q_ready)
    );

    slc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (pop_cmd),
        .i_pop   (pop)
    );

    slc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (pop_cmd),
        .o_pop       (pop),
        .o_tx_valid  (o_tx_valid),
        .i_tx_ready  (i_tx_ready),
        .o_tx_byte   (o_tx_byte),
        .o_tx_last   (o_tx_last)
    );
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the serial line calculator with predicted response bytes.
`timescale 1ns / 1ps
module tb_top;
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_tx_char;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_rx_valid;
    logic       o_rx_ready;
    logic [7:0] i_rx_byte;
    logic       o_tx_valid;
    logic       i_tx_ready;
    logic [7:0] o_tx_byte;
    logic       o_tx_last;

    t_tx_char   expected_chars[$];
    int         mismatch_count;
    bit         stall_enable = 1'b1;

    slc_pkg::t_line_stage m_stage;
    logic [7:0]           m_x;
    logic [7:0]           m_y;
    logic [7:0]           m_acc;
    slc_pkg::t_phase      m_phase;
    logic                 m_neg;
    logic [7:0]           m_first;
    logic [3:0]           m_pos;

    serial_line_calculator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_rx_byte  (i_rx_byte),
        .o_tx_valid (o_tx_valid),
        .i_tx_ready (i_tx_ready),
        .o_tx_byte  (o_tx_byte),
        .o_tx_last  (o_tx_last)
    );

    always #10 i_clk = ~i_clk;

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(20, 80);
        end
        if ($urandom_range(0, 2) == 0) begin
            return 0;
        end
        return $urandom_range(0, 3);
    endfunction

    function automatic void push_char(logic [7:0] c);
        t_tx_char e;
        e.ch = c;
        e.last = 1'b0;
        expected_chars.push_back(e);
    endfunction

    function automatic void push_decimal(int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i]);
        end
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i]);
        end
    endfunction

    function automatic void clear_line_state();
        m_acc = 8'd0;
        m_phase = slc_pkg::PH_BLANK;
        m_neg = 1'b0;
        m_first = 8'd0;
        m_pos = 4'd0;
    endfunction

    function automatic void predict_calc(logic [7:0] c);
        logic       is_digit;
        logic       is_blank;
        logic [7:0] val;
        logic [7:0] op;
        int         start_size;
        t_tx_char   e;
        is_digit = (c >= "0" && c <= "9");
        is_blank = (c == slc_pkg::CH_SPACE || c == 8'h09 || c == 8'h0B || c == 8'h0C);
        if (c != slc_pkg::CH_LF && c != slc_pkg::CH_CR) begin
            if (m_pos == 4'd0) begin
                m_first = c;
            end
            if (m_pos < 4'd15) begin
                m_pos = m_pos + 4'd1;
            end
            case (m_phase)
                slc_pkg::PH_BLANK: begin
                    if (is_blank) begin
                    end else if (c == slc_pkg::CH_PLUS || c == slc_pkg::CH_MINUS) begin
                        m_neg = (c == slc_pkg::CH_MINUS);
                        m_phase = slc_pkg::PH_SIGN;
                    end else if (is_digit) begin
                        m_acc = c - slc_pkg::CH_ZERO;
                        m_phase = slc_pkg::PH_DIGIT;
                    end else begin
                        m_phase = slc_pkg::PH_DONE;
                    end
                end
                slc_pkg::PH_SIGN, slc_pkg::PH_DIGIT: begin
                    if (is_digit) begin
                        m_acc = m_acc * 8'd10 + (c - slc_pkg::CH_ZERO);
                        m_phase = slc_pkg::PH_DIGIT;
                    end else begin
                        m_phase = slc_pkg::PH_DONE;
                    end
                end
                default: begin
                end
            endcase
            return;
        end
        val = m_neg ? 8'd0 - m_acc : m_acc;
        op = (m_pos == 4'd0) ? c : m_first;
        start_size = expected_chars.size();
        if (m_stage == slc_pkg::LS_FIRST) begin
            m_x = val;
        end else if (m_stage == slc_pkg::LS_SECOND) begin
            m_y = val;
        end else if (op == slc_pkg::CH_SLASH && m_y == 8'd0) begin
            push_text("Nie dziel cholero przez zero! \n");
        end else if (op == slc_pkg::CH_PLUS || op == slc_pkg::CH_MINUS ||
                     op == slc_pkg::CH_STAR || op == slc_pkg::CH_SLASH) begin
            push_decimal(32'(m_x));
            push_char(slc_pkg::CH_SPACE);
            push_char(op);
            push_char(slc_pkg::CH_SPACE);
            push_decimal(32'(m_y));
            push_text(" = ");
            if (op == slc_pkg::CH_PLUS) begin
                push_decimal(32'(m_x) + 32'(m_y));
            end else if (op == slc_pkg::CH_MINUS) begin
                if (m_x >= m_y) begin
                    push_decimal(32'(m_x - m_y));
                end else begin
                    push_char(slc_pkg::CH_MINUS);
                    push_decimal(32'(m_y - m_x));
                end
            end else if (op == slc_pkg::CH_STAR) begin
                push_decimal(32'(m_x) * 32'(m_y));
            end else begin
                push_decimal(32'(m_x / m_y));
            end
            push_text(" \n");
        end
        if (expected_chars.size() > start_size) begin
            e = expected_chars.pop_back();
            e.last = 1'b1;
            expected_chars.push_back(e);
        end
        m_stage = (m_stage == slc_pkg::LS_OPER) ? slc_pkg::LS_FIRST :
                  slc_pkg::t_line_stage'(m_stage + 2'd1);
        clear_line_state();
    endfunction

    task automatic send_byte(logic [7:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte <= c;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
        predict_calc(c);
    endtask

    task automatic send_line(string s, logic [7:0] term);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
        send_byte(term);
    endtask

    task automatic wait_drained();
        i_rx_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic test_directed_ops();
        send_line("255", slc_pkg::CH_LF);
        send_line("255", slc_pkg::CH_CR);
        send_line("*", slc_pkg::CH_LF);
        send_line(" \t+007", slc_pkg::CH_LF);
        send_line("-3", slc_pkg::CH_LF);
        send_line("-x", slc_pkg::CH_CR);
        send_line("0", slc_pkg::CH_LF);
        send_line("9", slc_pkg::CH_LF);
        send_line("/", slc_pkg::CH_LF);
        send_line("", slc_pkg::CH_LF);
        send_line("", slc_pkg::CH_CR);
        send_line("", slc_pkg::CH_LF);
        send_line("1000", slc_pkg::CH_LF);
        send_line("+-5", slc_pkg::CH_LF);
        send_line("%", slc_pkg::CH_LF);
        wait_drained();
    endtask

    task automatic test_random_lines();
        string ops;
        string s;
        int    n;
        logic [7:0] term;
        ops = "+-*/";
        for (int k = 0; k < 30; k++) begin
            for (int ln = 0; ln < 3; ln++) begin
                s = "";
                term = $urandom_range(0, 1) ? slc_pkg::CH_LF : slc_pkg::CH_CR;
                if ($urandom_range(0, 9) == 0) begin
                    n = $urandom_range(0, 5);
                    for (int i = 0; i < n; i++) begin
                        s = {s, string'(8'($urandom_range(0, 255)))};
                    end
                    for (int i = 0; i < s.len(); i++) begin
                        if (s[i] == slc_pkg::CH_LF || s[i] == slc_pkg::CH_CR ||
                            s[i] == 8'h00) begin
                            s[i] = "a";
                        end
                    end
                    send_byte(8'($urandom_range(128, 255)));
                end else if (ln == 2) begin
                    s = {string'(ops[$urandom_range(0, 3)]), "junk"};
                    if ($urandom_range(0, 5) == 0) begin
                        s = s.substr(0, 0);
                    end
                end else begin
                    if ($urandom_range(0, 3) == 0) begin
                        s = " ";
                    end
                    if ($urandom_range(0, 2) == 0) begin
                        if ($urandom_range(0, 1) != 0) begin
                            s = {s, "-"};
                        end else begin
                            s = {s, "+"};
                        end
                    end
                    s = {s, $sformatf("%0d", $urandom_range(0, 3) == 0 ? 0 :
                         $urandom_range(0, 999))};
                end
                send_line(s, term);
            end
            if (k == 15) begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_tx_ready <= 1'b0;
        end else begin
            i_tx_ready <= stall_enable ? ($urandom_range(0, 3) != 0) : 1'b1;
            if (o_tx_valid && i_tx_ready) begin
                if (expected_chars.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected char %h last %b", o_tx_byte, o_tx_last);
                    end
                end else begin
                    t_tx_char e;
                    e = expected_chars.pop_front();
                    if (e.ch !== o_tx_byte || e.last !== o_tx_last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch: expected %h/%b actual %h/%b",
                                     e.ch, e.last, o_tx_byte, o_tx_last);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) begin
            stall_enable <= ~stall_enable;
        end
    end

    initial begin
        mismatch_count = 0;
        i_rst_n = 1'b0;
        i_rx_valid = 1'b0;
        i_rx_byte = 8'd0;
        m_stage = slc_pkg::LS_FIRST;
        m_x = 8'd0;
        m_y = 8'd0;
        clear_line_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_ops();
        test_random_lines();
        if (mismatch_count == 0 && expected_chars.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
